// ===== design/cts_pkg.sv =====
`timescale 1ns / 1ps

package cts_pkg;

    localparam int ID_W   = 29;
    localparam int LEN_W  = 4;
    localparam int DATA_W = 64;
    localparam int OVF_W  = 16;

    // Queue entry layout: {length, extended, id, payload}
    localparam int ENTRY_W    = LEN_W + 1 + ID_W + DATA_W;
    localparam int E_ID_LO    = DATA_W;
    localparam int E_EXT_BIT  = DATA_W + ID_W;
    localparam int E_LEN_LO   = DATA_W + ID_W + 1;

    localparam logic [LEN_W-1:0] MAX_BYTES = 4'd8;

    localparam logic FUNC_ENQUEUE = 1'b0;
    localparam logic FUNC_SERVICE = 1'b1;

    typedef struct packed {
        logic step;         // request accepted this cycle
        logic load_launch;  // queue read data is valid, capture it
    } cts_cmd_t;

    typedef struct packed {
        logic launch;       // current request will pop and launch a frame
    } cts_status_t;

endpackage

// ===== design/cts_ram.sv =====
`timescale 1ns / 1ps

module cts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/cts_ctrl.sv =====
`timescale 1ns / 1ps

module cts_ctrl
    import cts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  cts_status_t status,
    output cts_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_HOLD  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = (state_reg == ST_HOLD);
    assign cmd.step        = in_valid && in_ready;
    assign cmd.load_launch = (state_reg == ST_FETCH);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    // a launch waits in ST_FETCH for the registered queue read
                    state_next = status.launch ? ST_FETCH : ST_HOLD;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/cts_datapath.sv =====
`timescale 1ns / 1ps

module cts_datapath
    import cts_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cts_cmd_t                       cmd,
    output cts_status_t                    status,
    input  logic                           func,
    input  logic [ID_W-1:0]                frame_id,
    input  logic                           extended_format,
    input  logic [LEN_W-1:0]               byte_count,
    input  logic [DATA_W-1:0]              payload,
    input  logic                           tx_complete,
    input  logic                           send_blocked,
    output logic                           accepted,
    output logic                           launched,
    output logic [ID_W-1:0]                launch_id,
    output logic                           launch_extended,
    output logic [LEN_W-1:0]               launch_length,
    output logic [DATA_W-1:0]              launch_payload,
    output logic [OVF_W-1:0]               overflow_total,
    output logic [$clog2(QUEUE_DEPTH):0]   queued_count,
    output logic                           awaiting_completion
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int PTR_W = IDX_W + 1;

    function automatic logic [DATA_W-1:0] keep_bytes(
        input logic [DATA_W-1:0] data,
        input logic [LEN_W-1:0]  len
    );
        logic [DATA_W-1:0] res;
        res = '0;
        for (int i = 0; i < DATA_W / 8; i++)
        begin
            if (LEN_W'(i) < len)
            begin
                res[8*i +: 8] = data[8*i +: 8];
            end
        end
        return res;
    endfunction

    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [OVF_W-1:0]  ovf_reg, ovf_next;
    logic              waiting_reg, waiting_next;
    logic              accepted_reg, accepted_next;
    logic              launched_reg;
    logic [PTR_W-1:0]  count_reg;
    logic [ID_W-1:0]   id_reg;
    logic              ext_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [DATA_W-1:0] data_reg;

    logic [PTR_W-1:0]   fill;
    logic               full;
    logic               empty;
    logic [LEN_W-1:0]   len_sat;
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    assign fill    = wptr_reg - rptr_reg;
    assign full    = fill[PTR_W-1];
    assign empty   = (wptr_reg == rptr_reg);
    assign len_sat = (byte_count > MAX_BYTES) ? MAX_BYTES : byte_count;

    assign status.launch = (func == FUNC_SERVICE) && !waiting_reg
                           && !send_blocked && !empty;

    assign ram_wdata = {len_sat, extended_format, frame_id, keep_bytes(payload, len_sat)};

    always_comb
    begin
        wptr_next     = wptr_reg;
        rptr_next     = rptr_reg;
        ovf_next      = ovf_reg;
        waiting_next  = waiting_reg;
        accepted_next = 1'b0;
        ram_we        = 1'b0;
        if (cmd.step)
        begin
            if (func == FUNC_ENQUEUE)
            begin
                if (!send_blocked)
                begin
                    if (full)
                    begin
                        // flush the queue and drop the frame
                        ovf_next  = ovf_reg + OVF_W'(1);
                        rptr_next = wptr_reg;
                    end
                    else
                    begin
                        ram_we        = 1'b1;
                        wptr_next     = wptr_reg + PTR_W'(1);
                        accepted_next = 1'b1;
                    end
                end
            end
            else if (waiting_reg)
            begin
                if (tx_complete)
                begin
                    waiting_next = 1'b0;
                end
            end
            else if (status.launch)
            begin
                rptr_next    = rptr_reg + PTR_W'(1);
                waiting_next = 1'b1;
            end
        end
    end

    cts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg[IDX_W-1:0]),
        .wdata (ram_wdata),
        .re    (cmd.step && status.launch),
        .raddr (rptr_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            ovf_reg      <= '0;
            waiting_reg  <= 1'b0;
            accepted_reg <= 1'b0;
            launched_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            wptr_reg    <= wptr_next;
            rptr_reg    <= rptr_next;
            ovf_reg     <= ovf_next;
            waiting_reg <= waiting_next;
            if (cmd.step)
            begin
                accepted_reg <= accepted_next;
                launched_reg <= status.launch;
                count_reg    <= wptr_next - rptr_next;
            end
        end
    end

    // Result fields: cleared on request, filled from the queue on a launch
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            id_reg   <= '0;
            ext_reg  <= 1'b0;
            len_reg  <= '0;
            data_reg <= '0;
        end
        else if (cmd.load_launch)
        begin
            id_reg   <= ram_rdata[E_ID_LO +: ID_W];
            ext_reg  <= ram_rdata[E_EXT_BIT];
            len_reg  <= ram_rdata[E_LEN_LO +: LEN_W];
            data_reg <= ram_rdata[DATA_W-1:0];
        end
    end

    assign accepted            = accepted_reg;
    assign launched            = launched_reg;
    assign launch_id           = id_reg;
    assign launch_extended     = ext_reg;
    assign launch_length       = len_reg;
    assign launch_payload      = data_reg;
    assign overflow_total      = ovf_reg;
    assign queued_count        = count_reg;
    assign awaiting_completion = waiting_reg;

endmodule

// ===== design/can_transmit_queue_sender_core.sv =====
`timescale 1ns / 1ps
// Timing: an enqueue or a non-launching service request gives its result in the cycle
// after acceptance; a launch first passes ST_FETCH for the registered queue read.
// One request at a time: a new request is taken only once the result has been taken,
// so an output stall holds the flow.
// Reset (rst_n, async, active low): pointers, overflow tally and sender state clear;
// queue contents are left undefined.

module can_transmit_queue_sender_core
    import cts_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         func,
    input  logic [ID_W-1:0]              frame_id,
    input  logic                         extended_format,
    input  logic [LEN_W-1:0]             byte_count,
    input  logic [DATA_W-1:0]            payload,
    input  logic                         tx_complete,
    input  logic                         send_blocked,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         accepted,
    output logic                         launched,
    output logic [ID_W-1:0]              launch_id,
    output logic                         launch_extended,
    output logic [LEN_W-1:0]             launch_length,
    output logic [DATA_W-1:0]            launch_payload,
    output logic [OVF_W-1:0]             overflow_total,
    output logic [$clog2(QUEUE_DEPTH):0] queued_count,
    output logic                         awaiting_completion
);

    cts_cmd_t    cmd;
    cts_status_t status;

    cts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    cts_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .func                (func),
        .frame_id            (frame_id),
        .extended_format     (extended_format),
        .byte_count          (byte_count),
        .payload             (payload),
        .tx_complete         (tx_complete),
        .send_blocked        (send_blocked),
        .accepted            (accepted),
        .launched            (launched),
        .launch_id           (launch_id),
        .launch_extended     (launch_extended),
        .launch_length       (launch_length),
        .launch_payload      (launch_payload),
        .overflow_total      (overflow_total),
        .queued_count        (queued_count),
        .awaiting_completion (awaiting_completion)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("request accepted while a result is pending");

    a_launch_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && launched) |-> (awaiting_completion && !accepted))
        else $error("launch result without sender waiting");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (queued_count <= QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_launch_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && launched) |-> (launch_length <= MAX_BYTES))
        else $error("launched length above eight bytes");

endmodule

// ===== tb/tb_can_transmit_queue_sender_core.sv =====
`timescale 1ns / 1ps

module tb_can_transmit_queue_sender_core;
    import cts_pkg::*;

    localparam int QDEPTH       = 16;
    localparam int SLOT_W       = $clog2(QDEPTH);
    localparam int CNT_W        = SLOT_W + 1;
    localparam int RANDOM_ITEMS = 1800;

    typedef struct packed {
        logic              func;
        logic [ID_W-1:0]   frame_id;
        logic              extended_format;
        logic [LEN_W-1:0]  byte_count;
        logic [DATA_W-1:0] data;
        logic              done;
        logic              blocked;
    } tx_request_t;

    typedef struct packed {
        logic              accepted;
        logic              launched;
        logic [ID_W-1:0]   launch_id;
        logic              launch_extended;
        logic [LEN_W-1:0]  launch_length;
        logic [DATA_W-1:0] launch_payload;
        logic [OVF_W-1:0]  overflow_total;
        logic [CNT_W-1:0]  queued_count;
        logic              awaiting_completion;
    } tx_result_t;

    typedef struct packed {
        tx_request_t req;
        logic [7:0]  reps;
        logic        typed;
        tx_result_t  want;
    } plan_row_t;

    logic                clk             = 1'b0;
    logic                rst_n           = 1'b0;
    logic                in_valid        = 1'b0;
    logic                in_ready;
    logic                func            = FUNC_ENQUEUE;
    logic [ID_W-1:0]     frame_id        = '0;
    logic                extended_format = 1'b0;
    logic [LEN_W-1:0]    byte_count      = '0;
    logic [DATA_W-1:0]   payload         = '0;
    logic                tx_complete     = 1'b0;
    logic                send_blocked    = 1'b0;
    logic                out_valid;
    logic                out_ready       = 1'b0;
    logic                accepted;
    logic                launched;
    logic [ID_W-1:0]     launch_id;
    logic                launch_extended;
    logic [LEN_W-1:0]    launch_length;
    logic [DATA_W-1:0]   launch_payload;
    logic [OVF_W-1:0]    overflow_total;
    logic [CNT_W-1:0]    queued_count;
    logic                awaiting_completion;

    // shadow of the frame queue and sender
    logic [ID_W-1:0]     shadow_id   [QDEPTH];
    logic                shadow_ext  [QDEPTH];
    logic [LEN_W-1:0]    shadow_len  [QDEPTH];
    logic [DATA_W-1:0]   shadow_data [QDEPTH];
    logic [CNT_W-1:0]    wr_ptr      = '0;
    logic [CNT_W-1:0]    rd_ptr      = '0;
    logic [OVF_W-1:0]    flush_count = '0;
    logic                sender_busy = 1'b0;

    tx_result_t          pending_results[$];
    plan_row_t           plan[$];
    int                  mismatch_count = 0;
    bit                  no_idle        = 1'b0;

    can_transmit_queue_sender_core #(
        .QUEUE_DEPTH(QDEPTH)
    ) u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .func               (func),
        .frame_id           (frame_id),
        .extended_format    (extended_format),
        .byte_count         (byte_count),
        .payload            (payload),
        .tx_complete        (tx_complete),
        .send_blocked       (send_blocked),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .accepted           (accepted),
        .launched           (launched),
        .launch_id          (launch_id),
        .launch_extended    (launch_extended),
        .launch_length      (launch_length),
        .launch_payload     (launch_payload),
        .overflow_total     (overflow_total),
        .queued_count       (queued_count),
        .awaiting_completion(awaiting_completion)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [CNT_W-1:0] queue_fill();
        return wr_ptr - rd_ptr;
    endfunction

    function automatic tx_result_t predict_tx_result(input tx_request_t req);
        tx_result_t       res;
        logic [LEN_W-1:0] len;
        logic [SLOT_W-1:0] slot;
        res = '0;
        len = (req.byte_count > MAX_BYTES) ? MAX_BYTES : req.byte_count;
        if (req.func == FUNC_ENQUEUE)
        begin
            if (!req.blocked)
            begin
                if (queue_fill() >= QDEPTH)
                begin
                    // full: count it, flush everything, drop the frame
                    flush_count = flush_count + OVF_W'(1);
                    rd_ptr = wr_ptr;
                end
                else
                begin
                    slot = wr_ptr[SLOT_W-1:0];
                    shadow_id[slot]  = req.frame_id;
                    shadow_ext[slot] = req.extended_format;
                    shadow_len[slot] = len;
                    shadow_data[slot] = (len >= MAX_BYTES) ? req.data
                        : req.data & ((64'd1 << (8 * len)) - 64'd1);
                    wr_ptr = wr_ptr + CNT_W'(1);
                    res.accepted = 1'b1;
                end
            end
        end
        else if (sender_busy)
        begin
            // only completion matters while waiting
            if (req.done)
                sender_busy = 1'b0;
        end
        else if (!req.blocked && queue_fill() != 0)
        begin
            slot = rd_ptr[SLOT_W-1:0];
            res.launched        = 1'b1;
            res.launch_id       = shadow_id[slot];
            res.launch_extended = shadow_ext[slot];
            res.launch_length   = shadow_len[slot];
            res.launch_payload  = shadow_data[slot];
            rd_ptr = rd_ptr + CNT_W'(1);
            sender_busy = 1'b1;
        end
        res.overflow_total      = flush_count;
        res.queued_count        = queue_fill();
        res.awaiting_completion = sender_busy;
        return res;
    endfunction

    function automatic tx_request_t make_request(input logic f, input logic [ID_W-1:0] id,
                                                 input logic ext, input logic [LEN_W-1:0] cnt,
                                                 input logic [DATA_W-1:0] data,
                                                 input logic done, input logic blocked);
        tx_request_t r;
        r.func            = f;
        r.frame_id        = id;
        r.extended_format = ext;
        r.byte_count      = cnt;
        r.data            = data;
        r.done            = done;
        r.blocked         = blocked;
        return r;
    endfunction

    function automatic tx_result_t quiet_result(input logic acc, input logic [CNT_W-1:0] cnt);
        tx_result_t r;
        r = '0;
        r.accepted     = acc;
        r.queued_count = cnt;
        return r;
    endfunction

    function automatic tx_request_t random_request(input int unsigned enq_pct);
        tx_request_t r;
        r.func = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQUEUE : FUNC_SERVICE;
        case ($urandom_range(0, 7))
            0:       r.frame_id = '0;
            1:       r.frame_id = '1;
            default: r.frame_id = ID_W'($urandom);
        endcase
        r.extended_format = 1'($urandom_range(0, 1));
        r.byte_count      = LEN_W'($urandom_range(0, 15));
        r.data            = {$urandom, $urandom};
        r.done            = ($urandom_range(0, 99) < 60);
        r.blocked         = ($urandom_range(0, 99) < 8);
        return r;
    endfunction

    task automatic add_row(input tx_request_t req, input int reps, input logic typed,
                           input tx_result_t want);
        plan_row_t row;
        row.req   = req;
        row.reps  = 8'(reps);
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    // entered and left at a falling edge
    task automatic issue_request(input tx_request_t req, input logic typed,
                                 input tx_result_t want);
        tx_result_t predicted;
        while (!no_idle && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        func            <= req.func;
        frame_id        <= req.frame_id;
        extended_format <= req.extended_format;
        byte_count      <= req.byte_count;
        payload         <= req.data;
        tx_complete     <= req.done;
        send_blocked    <= req.blocked;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = predict_tx_result(req);
        pending_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(negedge clk)
        out_ready <= no_idle || ($urandom_range(0, 99) >= 20);

    always @(posedge clk)
    begin : result_check
        tx_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual accepted %0b launched %0b",
                         $time, accepted, launched);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("accepted", 64'(want.accepted), 64'(accepted));
                check_field("launched", 64'(want.launched), 64'(launched));
                check_field("launch_id", 64'(want.launch_id), 64'(launch_id));
                check_field("launch_extended", 64'(want.launch_extended),
                            64'(launch_extended));
                check_field("launch_length", 64'(want.launch_length), 64'(launch_length));
                check_field("launch_payload", want.launch_payload, launch_payload);
                check_field("overflow_total", 64'(want.overflow_total), 64'(overflow_total));
                check_field("queued_count", 64'(want.queued_count), 64'(queued_count));
                check_field("awaiting_completion", 64'(want.awaiting_completion),
                            64'(awaiting_completion));
            end
        end
    end

    initial
    begin
        tx_result_t   none;
        int unsigned  burst_left;
        int unsigned  enq_pct;
        none       = '0;
        burst_left = 0;
        enq_pct    = 50;

        // service on empty, blocked enqueue, first store, zero-length store
        add_row(make_request(FUNC_SERVICE, '0, 1'b0, 4'd0, '0, 1'b0, 1'b0), 1, 1'b1,
                quiet_result(1'b0, CNT_W'(0)));
        add_row(make_request(FUNC_ENQUEUE, '1, 1'b1, 4'd15, '1, 1'b0, 1'b1), 1, 1'b1,
                quiet_result(1'b0, CNT_W'(0)));
        add_row(make_request(FUNC_ENQUEUE, '1, 1'b1, 4'd15, '1, 1'b1, 1'b0), 1, 1'b1,
                quiet_result(1'b1, CNT_W'(1)));
        add_row(make_request(FUNC_ENQUEUE, '0, 1'b0, 4'd0, '1, 1'b0, 1'b0), 1, 1'b0, none);
        // blocked idle service, launch ignoring completion, blocked wait, blocked done, launch, done
        add_row(make_request(FUNC_SERVICE, '0, 1'b0, 4'd0, '0, 1'b0, 1'b1), 1, 1'b0, none);
        add_row(make_request(FUNC_SERVICE, '0, 1'b0, 4'd0, '0, 1'b1, 1'b0), 1, 1'b0, none);
        add_row(make_request(FUNC_SERVICE, '0, 1'b0, 4'd0, '0, 1'b0, 1'b1), 1, 1'b0, none);
        add_row(make_request(FUNC_SERVICE, '0, 1'b0, 4'd0, '0, 1'b1, 1'b1), 1, 1'b0, none);
        add_row(make_request(FUNC_SERVICE, '0, 1'b0, 4'd0, '0, 1'b0, 1'b0), 1, 1'b0, none);
        add_row(make_request(FUNC_SERVICE, '0, 1'b0, 4'd0, '0, 1'b1, 1'b0), 1, 1'b0, none);
        // oversized and short lengths, then fill the queue up
        add_row(make_request(FUNC_ENQUEUE, 29'h0AAAAAAA, 1'b0, 4'd9,
                             64'h0123_4567_89AB_CDEF, 1'b0, 1'b0), 1, 1'b0, none);
        add_row(make_request(FUNC_ENQUEUE, 29'h15555555, 1'b1, 4'd3,
                             64'hFEDC_BA98_7654_3210, 1'b0, 1'b0), 1, 1'b0, none);
        add_row(make_request(FUNC_ENQUEUE, 29'h01234567, 1'b0, 4'd5,
                             64'h5A5A_A5A5_0F0F_F0F0, 1'b0, 1'b0), QDEPTH - 2, 1'b0, none);
        // blocked on full, overflow flush, service after flush, then a fresh frame launched and completed
        add_row(make_request(FUNC_ENQUEUE, '1, 1'b1, 4'd8, '1, 1'b0, 1'b1), 1, 1'b0, none);
        add_row(make_request(FUNC_ENQUEUE, '1, 1'b1, 4'd8, '1, 1'b0, 1'b0), 1, 1'b0, none);
        add_row(make_request(FUNC_SERVICE, '0, 1'b0, 4'd0, '0, 1'b0, 1'b0), 1, 1'b0, none);
        add_row(make_request(FUNC_ENQUEUE, 29'h1F0F0F0F, 1'b1, 4'd7, '1, 1'b0, 1'b0), 1,
                1'b0, none);
        add_row(make_request(FUNC_SERVICE, '0, 1'b0, 4'd0, '0, 1'b0, 1'b0), 1, 1'b0, none);
        add_row(make_request(FUNC_SERVICE, '0, 1'b0, 4'd0, '0, 1'b1, 1'b0), 1, 1'b0, none);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
            repeat (plan[i].reps)
                issue_request(plan[i].req, plan[i].typed, plan[i].want);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // switch between filling, draining and balanced traffic in bursts
            if (burst_left == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       enq_pct = 85;
                    1:       enq_pct = 25;
                    default: enq_pct = 55;
                endcase
                burst_left = $urandom_range(40, 120);
            end
            burst_left--;
            no_idle = (n >= 700 && n < 1000);
            if (n == 1200)
                drain_results();
            issue_request(random_request(enq_pct), 1'b0, none);
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
